>>> sv/lsr_pkg.sv
package lsr_pkg;

  localparam int DEF_LANES = 4;
  localparam int DEF_TAGS  = 16;

  // Depths of the two queues; both must be at least two.
  localparam int IQ_DEPTH = 2;
  localparam int OQ_DEPTH = 4;

  // Action codes of an input transaction.
  localparam logic [1:0] ACT_ADDR   = 2'd0;
  localparam logic [1:0] ACT_RSP    = 2'd1;
  localparam logic [1:0] ACT_FENCE  = 2'd2;
  localparam logic [1:0] ACT_NOADDR = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_LANE   = 2'd0;
  localparam logic [1:0] KIND_COMMIT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_BADRSP = 2'd3;

  typedef enum logic [1:0] {
    OP_ADDR,
    OP_RSP,
    OP_FENCE,
    OP_NOADDR
  } op_t;

  typedef enum logic {
    EX_IDLE,
    EX_RSP
  } exec_state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  instr_id;
    logic        write_op;
    logic [31:0] addr;
    logic        last_addr;
    logic [3:0]  rsp_tag;
    logic [2:0]  rsp_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  out_instr_id;
    logic [31:0] out_addr;
    logic [1:0]  out_lane;
    logic [3:0]  out_tag;
    logic        out_write;
    logic        out_req_last;
    logic        out_instr_last;
    logic        last;
  } result_t;

  // Item after decode, as it waits between the front and the back.
  typedef struct packed {
    op_t         op;
    logic [7:0]  instr_id;
    logic        write_op;
    logic [31:0] addr;
    logic        last_addr;
    logic [3:0]  rsp_tag;
    logic [2:0]  rsp_count;
    logic        tag_ok;
  } cls_item_t;

endpackage

>>> sv/lsr_fifo.sv
module lsr_fifo import lsr_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push_a,
  input  logic [W-1:0]                 data_a,
  input  logic                         push_b,
  input  logic [W-1:0]                 data_b,
  input  logic                         pop,
  output logic [W-1:0]                 head,
  output logic                         empty,
  output logic [$clog2(DEPTH + 1)-1:0] level
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem [DEPTH];
  logic [AW-1:0]   wr_ptr, wr_ptr_next, wr_ptr_b;
  logic [AW-1:0]   rd_ptr, rd_ptr_next;
  logic [CNTW-1:0] count, count_next;
  logic            do_pop;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // The second write slot must be used only together with the first; the FIFO itself does not enforce this.
  always_comb begin
    do_pop      = pop && (count != '0);
    wr_ptr_b    = wrap_inc(wr_ptr);
    wr_ptr_next = push_b ? wrap_inc(wr_ptr_b) : (push_a ? wr_ptr_b : wr_ptr);
    rd_ptr_next = do_pop ? wrap_inc(rd_ptr) : rd_ptr;
    count_next  = CNTW'(count + CNTW'(push_a) + CNTW'(push_b) - CNTW'(do_pop));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_ptr] <= data_a;
    end
    if (push_b) begin
      mem[wr_ptr_b] <= data_b;
    end
  end

  assign head  = mem[rd_ptr];
  assign empty = (count == '0);
  assign level = count;

endmodule

>>> sv/lsr_front.sv
module lsr_front import lsr_pkg::*; #(
  parameter int TAGS = DEF_TAGS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output cls_item_t head,
  output logic      head_valid,
  input  logic      head_pop
);

  localparam int QLW = $clog2(IQ_DEPTH + 1);

  cls_item_t      cls;
  logic           q_empty;
  logic [QLW-1:0] q_level;
  logic           accept;

  // Decode the action and check the response tag against the table size.
  always_comb begin
    cls.instr_id  = item.instr_id;
    cls.write_op  = item.write_op;
    cls.addr      = item.addr;
    cls.last_addr = item.last_addr;
    cls.rsp_tag   = item.rsp_tag;
    cls.rsp_count = item.rsp_count;
    cls.tag_ok    = (32'(item.rsp_tag) < TAGS);
    unique case (item.action)
      ACT_ADDR:   cls.op = OP_ADDR;
      ACT_RSP:    cls.op = OP_RSP;
      ACT_FENCE:  cls.op = OP_FENCE;
      ACT_NOADDR: cls.op = OP_NOADDR;
      default:    cls.op = OP_NOADDR;
    endcase
  end

  assign accept = push && !full;

  lsr_fifo #(
    .W     ($bits(cls_item_t)),
    .DEPTH (IQ_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push_a (accept),
    .data_a (cls),
    .push_b (1'b0),
    .data_b ('0),
    .pop    (head_pop),
    .head   (head),
    .empty  (q_empty),
    .level  (q_level)
  );

  assign full       = (q_level == QLW'(IQ_DEPTH));
  assign head_valid = !q_empty;

endmodule

>>> sv/lsr_exec.sv
module lsr_exec import lsr_pkg::*; #(
  parameter int LANES = DEF_LANES,
  parameter int TAGS  = DEF_TAGS
) (
  input  logic      clk,
  input  logic      rst,
  input  cls_item_t head,
  input  logic      head_valid,
  output logic      head_pop,
  input  logic      room,
  output logic      push_a,
  output result_t   res_a,
  output logic      push_b,
  output result_t   res_b
);

  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int TW = $clog2(TAGS);
  localparam int CW = $clog2(LANES + 1);
  localparam int VW = $clog2(TAGS + 1);

  typedef struct packed {
    logic [7:0]    instr;
    logic [CW-1:0] remaining;
    logic          fin;
  } entry_t;

  exec_state_t   state, state_next;
  logic [LW-1:0] lane_fill, lane_fill_next;
  logic [TW-1:0] open_tag, open_tag_next;
  logic          open_write, open_write_next;
  logic [7:0]    open_instr, open_instr_next;
  logic [CW-1:0] open_count, open_count_next;
  logic [TAGS-1:0] entry_valid, entry_valid_next;
  logic [VW-1:0] valid_count, valid_count_next;
  logic          fence_wait, fence_wait_next;
  logic [7:0]    fence_instr, fence_instr_next;

  entry_t        entry_mem [TAGS];
  entry_t        rd_entry;
  logic          mem_we;
  logic [TW-1:0] mem_waddr;
  entry_t        mem_wdata;

  logic [TW-1:0] free_tag;
  logic          free_any;
  logic [TW-1:0] rsp_idx;
  logic          starting;
  logic          eff_write;
  logic [TW-1:0] eff_tag;
  logic [7:0]    eff_instr;
  logic [CW-1:0] lanes_now;
  logic          req_last;
  logic          open_here;
  logic          rsp_bad;
  logic [CW-1:0] new_rem;

  function automatic result_t mk_result(input logic [1:0] kind, input logic [7:0] id,
                                        input logic [3:0] tag, input logic fin);
    result_t r;
    r                = '0;
    r.out_kind       = kind;
    r.out_instr_id   = id;
    r.out_tag        = tag;
    r.last           = fin;
    return r;
  endfunction

  // Lowest free tag.
  always_comb begin
    free_tag = '0;
    free_any = 1'b0;
    for (int i = TAGS - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_tag = TW'(i);
        free_any = 1'b1;
      end
    end
  end

  assign rsp_idx = TW'(head.rsp_tag);

  always_comb begin
    state_next       = state;
    lane_fill_next   = lane_fill;
    open_tag_next    = open_tag;
    open_write_next  = open_write;
    open_instr_next  = open_instr;
    open_count_next  = open_count;
    entry_valid_next = entry_valid;
    valid_count_next = valid_count;
    fence_wait_next  = fence_wait;
    fence_instr_next = fence_instr;
    mem_we           = 1'b0;
    mem_waddr        = rsp_idx;
    mem_wdata        = rd_entry;
    head_pop         = 1'b0;
    push_a           = 1'b0;
    push_b           = 1'b0;
    res_a            = '0;
    res_b            = '0;

    starting  = (lane_fill == '0);
    eff_write = starting ? head.write_op : open_write;
    eff_tag   = starting ? (head.write_op ? '0 : free_tag) : open_tag;
    eff_instr = starting ? head.instr_id : open_instr;
    lanes_now = CW'((starting ? '0 : open_count) + 1'b1);
    req_last  = head.last_addr || (lane_fill == LW'(LANES - 1));

    open_here = !starting && !open_write && (open_tag == rsp_idx);
    rsp_bad   = !head.tag_ok || !entry_valid[rsp_idx] || open_here
                || (32'(head.rsp_count) > 32'(rd_entry.remaining));
    new_rem   = CW'(32'(rd_entry.remaining) - 32'(head.rsp_count));

    unique case (state)
      EX_IDLE: begin
        if (head_valid && room) begin
          priority if (head.op == OP_RSP) begin
            // The entry is read this cycle and updated in the next.
            state_next = EX_RSP;
          end else if (fence_wait) begin
            head_pop = 1'b1;
            push_a   = 1'b1;
            res_a    = mk_result(KIND_REJECT, head.instr_id, 4'd0, 1'b1);
          end else if (head.op == OP_FENCE) begin
            head_pop = 1'b1;
            if (valid_count == '0) begin
              push_a = 1'b1;
              res_a  = mk_result(KIND_COMMIT, head.instr_id, 4'd0, 1'b1);
            end else begin
              fence_wait_next  = 1'b1;
              fence_instr_next = head.instr_id;
            end
          end else if (head.op == OP_NOADDR) begin
            head_pop = 1'b1;
            push_a   = 1'b1;
            res_a    = mk_result(KIND_COMMIT, head.instr_id, 4'd0, 1'b1);
          end else if (starting && !head.write_op && !free_any) begin
            head_pop = 1'b1;
            push_a   = 1'b1;
            res_a    = mk_result(KIND_REJECT, head.instr_id, 4'd0, 1'b1);
          end else begin
            head_pop = 1'b1;
            if (starting) begin
              open_write_next = head.write_op;
              open_tag_next   = eff_tag;
              open_instr_next = head.instr_id;
              if (!head.write_op) begin
                entry_valid_next[free_tag] = 1'b1;
                valid_count_next           = VW'(valid_count + 1'b1);
              end
            end
            open_count_next = lanes_now;
            if (!eff_write && req_last) begin
              mem_we              = 1'b1;
              mem_waddr           = eff_tag;
              mem_wdata.instr     = eff_instr;
              mem_wdata.remaining = lanes_now;
              mem_wdata.fin       = head.last_addr;
            end
            push_a               = 1'b1;
            res_a                = '0;
            res_a.out_kind       = KIND_LANE;
            res_a.out_instr_id   = head.instr_id;
            res_a.out_addr       = head.addr;
            res_a.out_lane       = 2'(lane_fill);
            res_a.out_tag        = eff_write ? 4'd0 : 4'(eff_tag);
            res_a.out_write      = eff_write;
            res_a.out_req_last   = req_last;
            res_a.out_instr_last = head.last_addr;
            res_a.last           = !(eff_write && head.last_addr);
            if (eff_write && head.last_addr) begin
              push_b = 1'b1;
              res_b  = mk_result(KIND_COMMIT, head.instr_id, 4'd0, 1'b1);
            end
            lane_fill_next = req_last ? '0 : LW'(lane_fill + 1'b1);
          end
        end
      end
      EX_RSP: begin
        if (room) begin
          head_pop   = 1'b1;
          state_next = EX_IDLE;
          if (rsp_bad) begin
            push_a = 1'b1;
            res_a  = mk_result(KIND_BADRSP, 8'd0, head.rsp_tag, 1'b1);
          end else begin
            mem_we              = 1'b1;
            mem_waddr           = rsp_idx;
            mem_wdata.remaining = new_rem;
            if (new_rem == '0) begin
              entry_valid_next[rsp_idx] = 1'b0;
              valid_count_next          = VW'(valid_count - 1'b1);
              if (rd_entry.fin) begin
                push_a = 1'b1;
                res_a  = mk_result(KIND_COMMIT, rd_entry.instr, 4'd0, 1'b1);
                if (fence_wait && (valid_count == VW'(1))) begin
                  fence_wait_next = 1'b0;
                  res_a.last      = 1'b0;
                  push_b          = 1'b1;
                  res_b = mk_result(KIND_COMMIT, fence_instr, 4'd0, 1'b1);
                end
              end else if (fence_wait && (valid_count == VW'(1))) begin
                fence_wait_next = 1'b0;
                push_a          = 1'b1;
                res_a = mk_result(KIND_COMMIT, fence_instr, 4'd0, 1'b1);
              end
            end
          end
        end
      end
      default: state_next = EX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= EX_IDLE;
      lane_fill   <= '0;
      open_tag    <= '0;
      open_write  <= 1'b0;
      open_count  <= '0;
      entry_valid <= '0;
      valid_count <= '0;
      fence_wait  <= 1'b0;
    end else begin
      state       <= state_next;
      lane_fill   <= lane_fill_next;
      open_tag    <= open_tag_next;
      open_write  <= open_write_next;
      open_count  <= open_count_next;
      entry_valid <= entry_valid_next;
      valid_count <= valid_count_next;
      fence_wait  <= fence_wait_next;
    end
  end

  always_ff @(posedge clk) begin
    open_instr  <= open_instr_next;
    fence_instr <= fence_instr_next;
  end

  // Pending-read table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    rd_entry <= entry_mem[rsp_idx];
  end

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    32'(valid_count) == $countones(entry_valid))
    else $error("valid count does not match the valid bits");

  a_fence_needs_entries: assert property (@(posedge clk) disable iff (rst)
    fence_wait |-> (valid_count != '0))
    else $error("fence waits on an empty table");

  a_open_load_valid: assert property (@(posedge clk) disable iff (rst)
    ((lane_fill != '0) && !open_write) |-> entry_valid[open_tag])
    else $error("open load request has no valid entry");

  a_second_slot: assert property (@(posedge clk) disable iff (rst)
    push_b |-> (push_a && res_b.last && !res_a.last))
    else $error("second result pushed without a first");

endmodule

>>> sv/lsu_request_splitter.sv
// Load/store unit request splitter.
// Input channel (push/full, item): one transaction is one active address of a
// memory instruction, a memory response, a fence, or a memory op that has no
// addresses. A transaction is taken when push is high and full is low.
// Result channel (empty/pop, result): the oldest result sits on result while
// empty is low and leaves when pop is high. A transaction gives zero, one or
// two results; the field last marks the final one of a transaction.
// Addresses are packed into memory requests of up to LANES lanes, and each
// load request owns the lowest free tag of a TAGS-entry pending-read table.
// A decode stage feeds a two-entry queue; the execute stage drains it and
// writes a four-entry result queue, so either side can stall on its own.
// An accepted transaction is registered in the input queue, and its results
// are then registered in the result queue; a response also waits for the
// registered table read. Throughput is one transaction per cycle while the
// result queue has room, except that a response is slower: its table entry
// is read through the single registered read port of the table memory, then
// written back. The execute stage waits while the result queue has fewer
// than two free slots; a stalled receiver fills the queues, then raises full.
// Reset empties both queues and the table and clears any waiting fence.
module lsu_request_splitter import lsr_pkg::*; #(
  parameter int LANES = DEF_LANES,
  parameter int TAGS  = DEF_TAGS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  output logic     empty,
  input  logic     pop,
  output result_t  result
);

  localparam int RLW = $clog2(OQ_DEPTH + 1);

  cls_item_t      head;
  logic           head_valid;
  logic           head_pop;
  logic           room;
  logic           push_a, push_b;
  result_t        res_a, res_b;
  logic [RLW-1:0] res_level;

  // Front: decode and queue incoming transactions.
  lsr_front #(
    .TAGS (TAGS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  // Back: lane packing, tag allocation, response and fence handling.
  lsr_exec #(
    .LANES (LANES),
    .TAGS  (TAGS)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .room       (room),
    .push_a     (push_a),
    .res_a      (res_a),
    .push_b     (push_b),
    .res_b      (res_b)
  );

  // Result queue; it takes up to two results per cycle.
  lsr_fifo #(
    .W     ($bits(result_t)),
    .DEPTH (OQ_DEPTH)
  ) u_results (
    .clk    (clk),
    .rst    (rst),
    .push_a (push_a),
    .data_a (res_a),
    .push_b (push_b),
    .data_b (res_b),
    .pop    (pop),
    .head   (result),
    .empty  (empty),
    .level  (res_level)
  );

  // The execute stage may write two results, so it needs two free slots.
  assign room = (res_level <= RLW'(OQ_DEPTH - 2));

endmodule
